// File: hdl/e2q_pkg.sv
// shared constants, tables and types for the euler to quaternion block
package e2q_pkg;

  localparam int CordicStepsDef = 24;
  localparam int TableLen       = 30;

  localparam int unsigned FullTurn    = 32'd47185920;
  localparam int unsigned HalfTurn    = 32'd23592960;
  localparam int unsigned QuarterTurn = 32'd11796480;

  localparam logic [32:0] ModOffset = 33'd2170552320;
  localparam logic [14:0] Recip      = 15'd23302;
  localparam int          RecipShift = 40;

  localparam logic [34:0] DegToRadQ40 = 35'd19190098069;
  localparam int          RadLoBits   = 18;
  localparam logic [17:0] RadLo       = DegToRadQ40[17:0];
  localparam logic [16:0] RadHi       = DegToRadQ40[34:18];

  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [33:0] OneQ30     = 34'sd1073741824;

  localparam logic [31:0] AtanQ30 [TableLen] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536,
    32'd32768, 32'd16384, 32'd8192, 32'd4096, 32'd2048,
    32'd1024, 32'd512, 32'd256, 32'd128, 32'd64,
    32'd32, 32'd16, 32'd8, 32'd4, 32'd2
  };

  typedef logic signed [31:0] e2q_q30_t;

  typedef struct packed {
    logic signed [33:0] z;
    logic               flip;
  } e2q_ang_t;

endpackage

// File: hdl/e2q_in_if.sv
// input channel: three euler angles
interface e2q_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pitch_deg;
  logic signed [31:0] yaw_deg;
  logic signed [31:0] roll_deg;

  modport source (output valid, output pitch_deg, output yaw_deg, output roll_deg,
                  input ready);
  modport sink (input valid, input pitch_deg, input yaw_deg, input roll_deg,
                output ready);
endinterface

// File: hdl/e2q_out_if.sv
// output channel: quaternion components
interface e2q_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;
  logic signed [31:0] quat_w;

  modport source (output valid, output quat_x, output quat_y, output quat_z,
                  output quat_w, input ready);
  modport sink (input valid, input quat_x, input quat_y, input quat_z,
                input quat_w, output ready);
endinterface

// File: hdl/euler_to_quaternion_top.sv
// euler angles to quaternion, top level
//
// in_i carries pitch, yaw and roll in degrees (signed Q16.16); out_o returns
// one quaternion transaction (x, y, z, w, signed Q1.30) per input transaction,
// in order. Both channels use valid/ready; a transaction moves when both are
// high at a rising clock edge.
// The pipeline runs angle reduction and degree to radian scaling, then a
// registered stage for each cordic iteration (CORDIC_STEPS, capped at 30),
// then the sign fold and the product tree. The last stage is the output
// register.
// Throughput is one transaction per cycle while out_o is not stalled; the three angles run in parallel
// lanes and every stage is registered.
// Reset clears only the valid bits, so the pipeline comes up empty and ready.
// When out_o is stalled with a result waiting, the whole pipeline holds;
// in_i.ready stays high while the output register is empty, so bubbles drain.
module euler_to_quaternion_top #(
  parameter int CORDIC_STEPS = e2q_pkg::CordicStepsDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  e2q_in_if.sink    in_i,
  e2q_out_if.source out_o
);
  import e2q_pkg::*;

  localparam int NSteps = (CORDIC_STEPS > TableLen) ? TableLen :
                          ((CORDIC_STEPS < 0) ? 0 : CORDIC_STEPS);
  localparam int Lat    = NSteps + 11;

  logic             en;
  logic [Lat-1:0]   vld_q;
  e2q_ang_t         ang_p, ang_y, ang_r;
  e2q_q30_t         sp, cp, sy, cy, sr, cr;

  assign en = !vld_q[Lat-1] || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_i.valid};
    end
  end

  e2q_angle u_ang_p (.clk_i, .en_i(en), .raw_i(in_i.pitch_deg), .ang_o(ang_p));
  e2q_angle u_ang_y (.clk_i, .en_i(en), .raw_i(in_i.yaw_deg),   .ang_o(ang_y));
  e2q_angle u_ang_r (.clk_i, .en_i(en), .raw_i(in_i.roll_deg),  .ang_o(ang_r));

  e2q_cordic #(.STEPS(NSteps)) u_cor_p (.clk_i, .en_i(en), .ang_i(ang_p),
                                        .sin_o(sp), .cos_o(cp));
  e2q_cordic #(.STEPS(NSteps)) u_cor_y (.clk_i, .en_i(en), .ang_i(ang_y),
                                        .sin_o(sy), .cos_o(cy));
  e2q_cordic #(.STEPS(NSteps)) u_cor_r (.clk_i, .en_i(en), .ang_i(ang_r),
                                        .sin_o(sr), .cos_o(cr));

  e2q_combine u_comb (
    .clk_i, .en_i(en),
    .sp_i(sp), .cp_i(cp), .sy_i(sy), .cy_i(cy), .sr_i(sr), .cr_i(cr),
    .qx_o(out_o.quat_x), .qy_o(out_o.quat_y), .qz_o(out_o.quat_z), .qw_o(out_o.quat_w)
  );

  assign in_i.ready  = en;
  assign out_o.valid = vld_q[Lat-1];

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> vld_q[0])
    else $error("accepted transaction not captured");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[Lat-1] |-> in_i.ready)
    else $error("input blocked with empty output register");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.quat_x <= 32'sd1073741824 && out_o.quat_x >= -32'sd1073741824
                  && out_o.quat_w <= 32'sd1073741824 && out_o.quat_w >= -32'sd1073741824))
    else $error("quaternion component out of range");
endmodule

// File: hdl/e2q_angle.sv
// half angle reduction, fold and degrees to radians, six stages
module e2q_angle (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] raw_i,
  output e2q_pkg::e2q_ang_t  ang_o
);
  import e2q_pkg::*;

  logic        [32:0] u_q, u2_q;
  logic        [7:0]  quo_q;
  logic        [25:0] r_q;
  logic        [23:0] mag_q;
  logic               neg_q, flip_q, neg2_q, flip2_q;
  logic        [41:0] pl_q;
  logic        [40:0] ph_q;
  e2q_ang_t           ang_q;

  logic signed [33:0] sum;
  logic        [47:0] prod;
  logic        [34:0] r0, r1;
  logic signed [26:0] s0, s1;
  logic               flip_d;
  logic        [58:0] t;
  logic        [31:0] zm;

  always_comb begin
    sum  = 34'(raw_i) + $signed({1'b0, ModOffset});
    prod = 48'(u_q) * 48'(Recip);
    r0   = {2'b0, u2_q} - 35'(quo_q) * 35'(FullTurn);
    r1   = r0[34] ? r0 + 35'(FullTurn) : r0;
    s0   = ({1'b0, r_q} >= 27'(HalfTurn)) ? $signed({1'b0, r_q}) - $signed(27'(FullTurn))
                                          : $signed({1'b0, r_q});
    flip_d = 1'b0;
    s1     = s0;
    if (s0 > $signed(27'(QuarterTurn))) begin
      s1     = s0 - $signed(27'(HalfTurn));
      flip_d = 1'b1;
    end else if (s0 < -$signed(27'(QuarterTurn))) begin
      s1     = s0 + $signed(27'(HalfTurn));
      flip_d = 1'b1;
    end
    t  = {ph_q, 18'b0} + 59'(pl_q) + 59'(1 << 26);
    zm = t[58:27];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q     <= sum[32:0];
      u2_q    <= u_q;
      quo_q   <= prod[RecipShift+7:RecipShift];
      r_q     <= r1[25:0];
      neg_q   <= s1[26];
      flip_q  <= flip_d;
      mag_q   <= s1[26] ? 24'(-s1) : 24'(s1);
      pl_q    <= 42'(mag_q) * 42'(RadLo);
      ph_q    <= 41'(mag_q) * 41'(RadHi);
      neg2_q  <= neg_q;
      flip2_q <= flip_q;
      ang_q.z    <= neg2_q ? -$signed({2'b0, zm}) : $signed({2'b0, zm});
      ang_q.flip <= flip2_q;
    end
  end

  assign ang_o = ang_q;
endmodule

// File: hdl/e2q_cordic.sv
// rotation mode cordic, one stage per iteration, then sign flip
module e2q_cordic #(
  parameter int STEPS = e2q_pkg::CordicStepsDef
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  e2q_pkg::e2q_ang_t   ang_i,
  output e2q_pkg::e2q_q30_t   sin_o,
  output e2q_pkg::e2q_q30_t   cos_o
);
  import e2q_pkg::*;

  logic signed [33:0] x_s [STEPS+1];
  logic signed [33:0] y_s [STEPS+1];
  logic signed [33:0] z_s [STEPS+1];
  logic               f_s [STEPS+1];
  e2q_q30_t           sin_q, cos_q;

  assign x_s[0] = CordicGain;
  assign y_s[0] = '0;
  assign z_s[0] = ang_i.z;
  assign f_s[0] = ang_i.flip;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [33:0] xq, yq, zq;
    logic               fq;
    logic signed [33:0] at;
    assign at = $signed({2'b0, AtanQ30[i]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_s[i] >= 0) begin
          xq <= x_s[i] - (y_s[i] >>> i);
          yq <= y_s[i] + (x_s[i] >>> i);
          zq <= z_s[i] - at;
        end else begin
          xq <= x_s[i] + (y_s[i] >>> i);
          yq <= y_s[i] - (x_s[i] >>> i);
          zq <= z_s[i] + at;
        end
        fq <= f_s[i];
      end
    end
    assign x_s[i+1] = xq;
    assign y_s[i+1] = yq;
    assign z_s[i+1] = zq;
    assign f_s[i+1] = fq;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= f_s[STEPS] ? 32'(-x_s[STEPS]) : 32'(x_s[STEPS]);
      sin_q <= f_s[STEPS] ? 32'(-y_s[STEPS]) : 32'(y_s[STEPS]);
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;
endmodule

// File: hdl/e2q_combine.sv
// quaternion products, four stages: pair, round, triple, round sum clamp
module e2q_combine (
  input  logic              clk_i,
  input  logic              en_i,
  input  e2q_pkg::e2q_q30_t sp_i,
  input  e2q_pkg::e2q_q30_t cp_i,
  input  e2q_pkg::e2q_q30_t sy_i,
  input  e2q_pkg::e2q_q30_t cy_i,
  input  e2q_pkg::e2q_q30_t sr_i,
  input  e2q_pkg::e2q_q30_t cr_i,
  output e2q_pkg::e2q_q30_t qx_o,
  output e2q_pkg::e2q_q30_t qy_o,
  output e2q_pkg::e2q_q30_t qz_o,
  output e2q_pkg::e2q_q30_t qw_o
);
  import e2q_pkg::*;

  function automatic logic signed [33:0] rnd(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd536870912;
    return 34'(t >>> 30);
  endfunction

  function automatic e2q_q30_t clamp(input logic signed [33:0] v);
    logic signed [33:0] c;
    c = v;
    if (v > OneQ30) c = OneQ30;
    else if (v < -OneQ30) c = -OneQ30;
    return 32'(c);
  endfunction

  logic signed [63:0] pa_q, pb_q, pc_q, pd_q;
  e2q_q30_t           sy1_q, cy1_q, sy2_q, cy2_q;
  e2q_q30_t           ra_q, rb_q, rc_q, rd_q;
  logic signed [63:0] t_q [8];
  e2q_q30_t           qx_q, qy_q, qz_q, qw_q;
  logic signed [33:0] v [8];

  always_comb begin
    for (int k = 0; k < 8; k++) v[k] = rnd(t_q[k]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q  <= cr_i * sp_i;
      pb_q  <= sr_i * cp_i;
      pc_q  <= cr_i * cp_i;
      pd_q  <= sr_i * sp_i;
      sy1_q <= sy_i;
      cy1_q <= cy_i;
      ra_q  <= 32'(rnd(pa_q));
      rb_q  <= 32'(rnd(pb_q));
      rc_q  <= 32'(rnd(pc_q));
      rd_q  <= 32'(rnd(pd_q));
      sy2_q <= sy1_q;
      cy2_q <= cy1_q;
      t_q[0] <= ra_q * sy2_q;
      t_q[1] <= rb_q * cy2_q;
      t_q[2] <= ra_q * cy2_q;
      t_q[3] <= rb_q * sy2_q;
      t_q[4] <= rc_q * sy2_q;
      t_q[5] <= rd_q * cy2_q;
      t_q[6] <= rc_q * cy2_q;
      t_q[7] <= rd_q * sy2_q;
      qx_q <= clamp(v[0] - v[1]);
      qy_q <= clamp(-v[2] - v[3]);
      qz_q <= clamp(v[4] - v[5]);
      qw_q <= clamp(v[6] + v[7]);
    end
  end

  assign qx_o = qx_q;
  assign qy_o = qy_q;
  assign qz_o = qz_q;
  assign qw_o = qw_q;
endmodule

// File: tb/e2q_tb_pkg.sv
`timescale 1ns / 1ps
// shared quaternion and euler angle transaction types for the testbench
package e2q_tb_pkg;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
  } quat_t;

  typedef struct packed {
    logic signed [31:0] pitch;
    logic signed [31:0] yaw;
    logic signed [31:0] roll;
  } euler_t;

endpackage

// File: tb/euler_to_quaternion_top_test.sv
`timescale 1ns / 1ps
// testbench for euler_to_quaternion_top: random and directed angles checked against a predictor
module euler_to_quaternion_top_test;
  import e2q_tb_pkg::*;

  localparam int NumRandom  = 1530;
  localparam int IdleLimit  = 20000;
  localparam int Latency    = 35;
  localparam longint FullTurnL = 47185920;
  localparam longint HalfTurnL = 23592960;
  localparam longint QuarterTurnL = 11796480;
  localparam longint GainQ30  = 652032874;
  localparam longint UnitQ30  = 1073741824;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  e2q_in_if  in_if ();
  e2q_out_if out_if ();

  euler_to_quaternion_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #1 clk_i = ~clk_i;

  euler_t angle_queue [$];
  quat_t  quat_expected [$];
  int     error_count = 0;
  int     idle_cycles = 0;
  bit     stimulus_done = 1'b0;
  bit     hold_sender = 1'b0;
  bit     in_taken = 1'b0;
  int     sink_hold = 0;
  int     long_hold_request = 0;
  int     send_gap = 0;

  function automatic longint shift_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint mul_round(longint a, longint b);
    return shift_floor(a * b + (longint'(1) << 29), 30);
  endfunction

  function automatic void half_angle_trig(logic signed [31:0] raw, output longint s,
                                          output longint c);
    longint r, mag, z, x, y, dx, dy;
    bit flip, neg;
    logic [63:0] prod;
    longint atan_tab [30] = '{
      843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149,
      1048576, 524288, 262144, 131072, 65536,
      32768, 16384, 8192, 4096, 2048,
      1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
    r = longint'(raw) % FullTurnL;
    flip = 1'b0;
    if (r < 0) r += FullTurnL;
    if (r >= HalfTurnL) r -= FullTurnL;
    if (r > QuarterTurnL) begin
      r -= HalfTurnL;
      flip = 1'b1;
    end else if (r < -QuarterTurnL) begin
      r += HalfTurnL;
      flip = 1'b1;
    end
    neg = r < 0;
    mag = neg ? -r : r;
    prod = 64'(mag) * 64'd19190098069 + (64'd1 << 26);
    z = longint'(prod >> 27);
    if (neg) z = -z;
    x = GainQ30;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      dx = shift_floor(y, i);
      dy = shift_floor(x, i);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_tab[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_tab[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic logic signed [31:0] clamp_unit(longint v);
    if (v > UnitQ30) return 32'(UnitQ30);
    if (v < -UnitQ30) return 32'(-UnitQ30);
    return 32'(v);
  endfunction

  function automatic quat_t predict_quat(euler_t a);
    longint sp, cp, sy, cy, sr, cr;
    quat_t q;
    half_angle_trig(a.pitch, sp, cp);
    half_angle_trig(a.yaw, sy, cy);
    half_angle_trig(a.roll, sr, cr);
    q.x = clamp_unit(mul_round(mul_round(cr, sp), sy) - mul_round(mul_round(sr, cp), cy));
    q.y = clamp_unit(-mul_round(mul_round(cr, sp), cy) - mul_round(mul_round(sr, cp), sy));
    q.z = clamp_unit(mul_round(mul_round(cr, cp), sy) - mul_round(mul_round(sr, sp), cy));
    q.w = clamp_unit(mul_round(mul_round(cr, cp), cy) + mul_round(mul_round(sr, sp), sy));
    return q;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
    error_count++;
  endtask

  function automatic int random_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [31:0] random_angle();
    int p;
    p = $urandom_range(0, 3);
    case (p)
      0: return $urandom();
      1: return $signed($urandom_range(0, 47185920)) - 23592960;
      2: return ($signed($urandom_range(0, 16)) - 8) * 32'sd5898240
                + $signed($urandom_range(0, 6)) - 3;
      default: return $signed($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  function automatic void push_angles(logic signed [31:0] p, logic signed [31:0] y,
                                      logic signed [31:0] r);
    euler_t a;
    a.pitch = p;
    a.yaw = y;
    a.roll = r;
    angle_queue = {angle_queue, a};
  endfunction

  initial begin
    logic signed [31:0] corner [12] = '{
      32'sh0, 32'sh7fffffff, 32'sh80000000, 32'shffffffff, 32'sd1,
      32'sd5898240, -32'sd5898240, 32'sd11796480, 32'sd23592960,
      -32'sd23592960, 32'sd47185920, 32'sd11796481};
    for (int i = 0; i < 12; i++)
      push_angles(corner[i], corner[(i + 4) % 12], corner[(i + 8) % 12]);
    push_angles(32'sh55555555, 32'shaaaaaaaa, 32'sh7fffffff);
    push_angles(32'shaaaaaaaa, 32'sh55555555, 32'sh80000000);
    for (int i = 0; i < NumRandom; i++)
      push_angles(random_angle(), random_angle(), random_angle());
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (angle_queue.size() < 1300);
    long_hold_request = 300;
    wait (angle_queue.size() < 700);
    hold_sender = 1'b1;
    wait (quat_expected.size() == 0);
    @(negedge clk_i);
    hold_sender = 1'b0;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.pitch_deg <= '0;
      in_if.yaw_deg <= '0;
      in_if.roll_deg <= '0;
    end else if (in_if.valid && !in_taken) begin
    end else if (send_gap > 0) begin
      in_if.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (angle_queue.size() > 0 && !hold_sender) begin
      euler_t a;
      a = angle_queue.pop_front();
      in_if.valid <= 1'b1;
      in_if.pitch_deg <= a.pitch;
      in_if.yaw_deg <= a.yaw;
      in_if.roll_deg <= a.roll;
      send_gap <= random_gap();
    end else begin
      in_if.valid <= 1'b0;
      if (angle_queue.size() == 0) stimulus_done <= 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (long_hold_request > 0) begin
      out_if.ready <= 1'b0;
      sink_hold <= long_hold_request;
      long_hold_request = 0;
    end else if (sink_hold > 0) begin
      out_if.ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      out_if.ready <= 1'b1;
      sink_hold <= random_gap();
    end
  end

  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (in_if.valid && in_if.ready) begin
        euler_t a;
        a.pitch = in_if.pitch_deg;
        a.yaw = in_if.yaw_deg;
        a.roll = in_if.roll_deg;
        quat_expected = {quat_expected, predict_quat(a)};
      end
      if (out_if.valid && out_if.ready) begin
        if (quat_expected.size() == 0) begin
          $display("unexpected quaternion transaction");
          error_count++;
        end else begin
          quat_t q;
          q = quat_expected.pop_front();
          if (out_if.quat_x !== q.x) report_mismatch("quat_x", out_if.quat_x, q.x);
          if (out_if.quat_y !== q.y) report_mismatch("quat_y", out_if.quat_y, q.y);
          if (out_if.quat_z !== q.z) report_mismatch("quat_z", out_if.quat_z, q.z);
          if (out_if.quat_w !== q.w) report_mismatch("quat_w", out_if.quat_w, q.w);
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("euler_to_quaternion_top_test failed");
        $finish;
      end
    end
  end

  initial begin
    wait (stimulus_done && quat_expected.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    if (error_count == 0 && quat_expected.size() == 0)
      $display("euler_to_quaternion_top_test passed");
    else
      $display("euler_to_quaternion_top_test failed");
    $finish;
  end

endmodule
